@@ hw/rtl/lmne_pkg.sv @@
package lmne_pkg;

   localparam int NUM_W      = 10;
   localparam int STYLE_W    = 3;
   localparam int CODE_W     = 11;
   localparam int CNT_W      = 6;
   localparam int SEG_NUM    = 7;
   localparam int SEG_IDX_W  = $clog2(SEG_NUM);
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam int MAX_NUMBER        = 1023;
   localparam int LMNE_QUEUE_DEPTH  = 2;

   typedef enum logic [STYLE_W-1:0] {
      STYLE_DECIMAL     = 3'd0,
      STYLE_LOWER_ROMAN = 3'd1,
      STYLE_UPPER_ROMAN = 3'd2,
      STYLE_LOWER_GREEK = 3'd3,
      STYLE_HEBREW      = 3'd4,
      STYLE_LOWER_ALPHA = 3'd5,
      STYLE_UPPER_ALPHA = 3'd6
   } style_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIV,
      FRONT_PLAN
   } front_state_type;

   // one run of identical characters
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [CNT_W-1:0]  count;
   } seg_type;

   // a whole label, runs emitted from index 0 upward, empty runs skipped
   typedef struct packed {
      seg_type [SEG_NUM-1:0] segs;
   } plan_type;

endpackage

@@ hw/rtl/list_marker_numeral_encoder.sv @@
// List marker label encoder. Each request word carries a list item number
// (1..1023, larger values clamp to 1023) and returns the code points of its
// marker label, one response word per character, tlast on the final one.
// The style register picks decimal, lower/upper Roman, lower Greek, Hebrew
// or lower/upper Latin letters; write it only while no label is in flight.
// Number zero gives "0" in decimal and an empty label (no words) otherwise;
// style 7 gives no words. Labels run up to 43 characters. The front end
// steps through accept, three divide-by-ten steps and label plan for each
// item and takes no new item until its plan is pushed; the back end loads a
// plan, then emits one character per cycle while the response side does
// not stall; a two-deep plan queue between them absorbs stalls.
module list_marker_numeral_encoder import lmne_pkg::*; #(
   parameter int QUEUE_DEPTH = LMNE_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [9:0] item_number
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [10:0] char_code
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [STYLE_W-1:0]    csr_data     // [2:0] numbering_style
);

   style_type          style_ff;
   logic               push_valid, push_ready;
   plan_type           push_plan;
   logic               pop_valid, pop_ready;
   plan_type           pop_plan;
   logic [CODE_W-1:0]  rsp_code;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff <= STYLE_DECIMAL;
      end else if (csr_valid && csr_ready) begin
         style_ff <= style_type'(csr_data);
      end
   end

   lmne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_number (req_tdata[NUM_W-1:0]),
      .style      (style_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_plan  (push_plan)
   );

   lmne_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_plan  (push_plan),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_plan   (pop_plan)
   );

   lmne_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_plan   (pop_plan),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_code   (rsp_code),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_code);

endmodule

@@ hw/rtl/lmne_front.sv @@
module lmne_front import lmne_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [NUM_W-1:0]   req_number,
   input  style_type          style,
   output logic               push_valid,
   input  logic               push_ready,
   output plan_type           push_plan
);

   localparam int DIGIT_STEPS = 3;
   localparam int DIV10_MUL   = 205;
   localparam int DIV10_SHIFT = 11;
   localparam int CYC_SHIFT   = 17;
   localparam int DIV24_MUL   = 5462;
   localparam int DIV26_MUL   = 5042;
   localparam int MUL_W       = 13;
   localparam int PROD_W      = NUM_W + MUL_W;
   localparam int QUO_W       = 7;

   localparam logic [CODE_W-1:0] CH_ZERO     = CODE_W'(48);
   localparam logic [CODE_W-1:0] CH_APOS     = CODE_W'(39);
   localparam logic [CODE_W-1:0] CH_LOWER_A  = CODE_W'(97);
   localparam logic [CODE_W-1:0] CH_UPPER_A  = CODE_W'(65);
   localparam logic [CODE_W-1:0] CH_ALPHA    = CODE_W'(945);
   localparam logic [CODE_W-1:0] CH_R_I      = CODE_W'(73);
   localparam logic [CODE_W-1:0] CH_R_V      = CODE_W'(86);
   localparam logic [CODE_W-1:0] CH_R_X      = CODE_W'(88);
   localparam logic [CODE_W-1:0] CH_R_L      = CODE_W'(76);
   localparam logic [CODE_W-1:0] CH_R_C      = CODE_W'(67);
   localparam logic [CODE_W-1:0] CH_R_D      = CODE_W'(68);
   localparam logic [CODE_W-1:0] CH_R_M      = CODE_W'(77);
   localparam logic [CODE_W-1:0] CASE_OFFSET = CODE_W'(32);
   localparam logic [CODE_W-1:0] HEB_ALEF    = CODE_W'(1488);
   localparam logic [CODE_W-1:0] HEB_TET     = CODE_W'(1496);
   localparam logic [CODE_W-1:0] HEB_UNIT0   = CODE_W'(1487);
   localparam logic [CODE_W-1:0] HEB_QOF0    = CODE_W'(1510);
   localparam logic [CODE_W-1:0] HEB_TAV     = CODE_W'(1514);

   typedef seg_type [1:0] seg_pair_type;

   function automatic logic [CODE_W-1:0] hebrew_tens(input logic [3:0] t);
      logic [CODE_W-1:0] c;
      case (t)
         4'd1:    c = CODE_W'(1497);
         4'd2:    c = CODE_W'(1499);
         4'd3:    c = CODE_W'(1500);
         4'd4:    c = CODE_W'(1502);
         4'd5:    c = CODE_W'(1504);
         4'd6:    c = CODE_W'(1505);
         4'd7:    c = CODE_W'(1506);
         4'd8:    c = CODE_W'(1508);
         4'd9:    c = CODE_W'(1510);
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic seg_pair_type roman_pair(input logic [3:0] v,
                                               input logic [CODE_W-1:0] one,
                                               input logic [CODE_W-1:0] five,
                                               input logic [CODE_W-1:0] ten);
      seg_pair_type p;
      p[0].code  = one;
      p[0].count = CNT_W'(1);
      if (v == 4'd9) begin
         p[1].code  = ten;
         p[1].count = CNT_W'(1);
      end else if (v == 4'd4) begin
         p[1].code  = five;
         p[1].count = CNT_W'(1);
      end else begin
         p[0].code  = five;
         p[0].count = CNT_W'(v >= 4'd5);
         p[1].code  = one;
         p[1].count = (v >= 4'd5) ? CNT_W'(v - 4'd5) : CNT_W'(v);
      end
      return p;
   endfunction

   front_state_type state_ff, state_in;
   logic [1:0]             step_ff, step_in;
   logic [NUM_W-1:0]       n_ff;
   logic [NUM_W-1:0]       x_ff;
   logic [2:0][3:0]        dig_ff;
   style_type              style_ff;
   logic [CNT_W-1:0]       cq_ff;
   logic [4:0]             cr_ff;

   logic [NUM_W-1:0]       number_clamped;
   logic [NUM_W+QUO_W:0]   div10_prod;
   logic [QUO_W-1:0]       div10_quo;
   logic [NUM_W-1:0]       div10_rem;
   logic                   greek;
   logic [NUM_W-1:0]       m_val;
   logic [PROD_W-1:0]      cyc_prod;
   logic [NUM_W-1:0]       cyc_span_mul;
   logic [NUM_W-1:0]       cyc_rem;
   logic [3:0]             dig_u, dig_t, dig_h, dig_th;
   logic                   n_zero;
   logic [4:0]             greek_idx;
   logic [CODE_W-1:0]      rom_off;
   seg_pair_type           rom_h, rom_t, rom_u;
   plan_type               plan;

   assign number_clamped = (req_number > NUM_W'(MAX_NUMBER)) ? NUM_W'(MAX_NUMBER) : req_number;

   // divide by ten: reciprocal multiply, exact below 1029
   assign div10_prod = (NUM_W+QUO_W+1)'(x_ff) * (NUM_W+QUO_W+1)'(DIV10_MUL);
   assign div10_quo  = div10_prod[DIV10_SHIFT +: QUO_W];
   assign div10_rem  = x_ff - NUM_W'({div10_quo, 3'b000}) - NUM_W'({div10_quo, 1'b0});

   assign greek = (style_ff == STYLE_LOWER_GREEK);
   assign m_val = n_ff - NUM_W'(1);
   assign cyc_prod = PROD_W'(m_val) *
                     (greek ? PROD_W'(DIV24_MUL) : PROD_W'(DIV26_MUL));
   // quotient times 24 or 26
   assign cyc_span_mul = NUM_W'({cq_ff, 4'b0000}) + NUM_W'({cq_ff, 3'b000}) +
                         (greek ? NUM_W'(0) : NUM_W'({cq_ff, 1'b0}));
   assign cyc_rem = m_val - cyc_span_mul;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      req_tready = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         FRONT_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = FRONT_DIV;
               step_in  = '0;
            end
         end
         FRONT_DIV: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'(DIGIT_STEPS - 1)) begin
               state_in = FRONT_PLAN;
            end
         end
         FRONT_PLAN: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         n_ff     <= number_clamped;
         x_ff     <= number_clamped;
         style_ff <= style;
      end
      if (state_ff == FRONT_DIV) begin
         x_ff   <= NUM_W'(div10_quo);
         dig_ff <= {div10_rem[3:0], dig_ff[2:1]};
         if (step_ff == 2'd0) begin
            cq_ff <= cyc_prod[CYC_SHIFT +: CNT_W];
         end
         if (step_ff == 2'd1) begin
            cr_ff <= cyc_rem[4:0];
         end
      end
   end

   assign dig_u  = dig_ff[0];
   assign dig_t  = dig_ff[1];
   assign dig_h  = dig_ff[2];
   assign dig_th = x_ff[3:0];
   assign n_zero = (n_ff == '0);

   assign greek_idx = (cr_ff > 5'd16) ? cr_ff + 5'd1 : cr_ff;
   assign rom_off   = (style_ff == STYLE_LOWER_ROMAN) ? CASE_OFFSET : '0;
   assign rom_h = roman_pair(dig_h, CH_R_C + rom_off, CH_R_D + rom_off, CH_R_M + rom_off);
   assign rom_t = roman_pair(dig_t, CH_R_X + rom_off, CH_R_L + rom_off, CH_R_C + rom_off);
   assign rom_u = roman_pair(dig_u, CH_R_I + rom_off, CH_R_V + rom_off, CH_R_X + rom_off);

   always_comb begin
      plan = '0;
      case (style_ff)
         STYLE_DECIMAL: begin
            // drop leading zeros, always keep the units digit
            plan.segs[0].code  = CH_ZERO + CODE_W'(dig_th);
            plan.segs[0].count = CNT_W'(dig_th != 4'd0);
            plan.segs[1].code  = CH_ZERO + CODE_W'(dig_h);
            plan.segs[1].count = CNT_W'((dig_th | dig_h) != 4'd0);
            plan.segs[2].code  = CH_ZERO + CODE_W'(dig_t);
            plan.segs[2].count = CNT_W'((dig_th | dig_h | dig_t) != 4'd0);
            plan.segs[3].code  = CH_ZERO + CODE_W'(dig_u);
            plan.segs[3].count = CNT_W'(1);
         end
         STYLE_LOWER_ROMAN, STYLE_UPPER_ROMAN: begin
            if (!n_zero) begin
               plan.segs[0].code  = CH_R_M + rom_off;
               plan.segs[0].count = CNT_W'(dig_th);
               plan.segs[1]       = rom_h[0];
               plan.segs[2]       = rom_h[1];
               plan.segs[3]       = rom_t[0];
               plan.segs[4]       = rom_t[1];
               plan.segs[5]       = rom_u[0];
               plan.segs[6]       = rom_u[1];
            end
         end
         STYLE_LOWER_GREEK, STYLE_LOWER_ALPHA, STYLE_UPPER_ALPHA: begin
            if (!n_zero) begin
               case (style_ff)
                  STYLE_LOWER_GREEK: plan.segs[0].code = CH_ALPHA + CODE_W'(greek_idx);
                  STYLE_LOWER_ALPHA: plan.segs[0].code = CH_LOWER_A + CODE_W'(cr_ff);
                  default:           plan.segs[0].code = CH_UPPER_A + CODE_W'(cr_ff);
               endcase
               plan.segs[0].count = CNT_W'(1);
               plan.segs[1].code  = CH_APOS;
               plan.segs[1].count = cq_ff;
            end
         end
         STYLE_HEBREW: begin
            if (!n_zero) begin
               // at or above 1000 the hundreds digit is zero, so tav and
               // hundreds letter drop out on their own
               plan.segs[0].code  = HEB_ALEF;
               plan.segs[0].count = CNT_W'(dig_th != 4'd0);
               plan.segs[1].code  = CH_APOS;
               plan.segs[1].count = CNT_W'(dig_th != 4'd0);
               plan.segs[2].code  = HEB_TAV;
               plan.segs[2].count = CNT_W'(dig_h[3:2]);
               plan.segs[3].code  = HEB_QOF0 + CODE_W'(dig_h[1:0]);
               plan.segs[3].count = CNT_W'(dig_h[1:0] != 2'd0);
               if (dig_t == 4'd1 && (dig_u == 4'd5 || dig_u == 4'd6)) begin
                  plan.segs[4].code  = HEB_TET;
                  plan.segs[4].count = CNT_W'(1);
                  plan.segs[5].code  = HEB_ALEF + CODE_W'(dig_u);
                  plan.segs[5].count = CNT_W'(1);
               end else begin
                  plan.segs[4].code  = hebrew_tens(dig_t);
                  plan.segs[4].count = CNT_W'(dig_t != 4'd0);
                  plan.segs[5].code  = HEB_UNIT0 + CODE_W'(dig_u);
                  plan.segs[5].count = CNT_W'(dig_u != 4'd0);
               end
            end
         end
         default: begin
            plan = '0;
         end
      endcase
   end

   assign push_plan = plan;

endmodule

@@ hw/rtl/lmne_queue.sv @@
module lmne_queue import lmne_pkg::*; #(
   parameter int DEPTH = LMNE_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  plan_type push_plan,
   output logic     pop_valid,
   input  logic     pop_ready,
   output plan_type pop_plan
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   plan_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = (fill_ff != CNT_QW'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_plan   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_plan;
      end
   end

endmodule

@@ hw/rtl/lmne_back.sv @@
module lmne_back import lmne_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  plan_type          pop_plan,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CODE_W-1:0] rsp_code,
   output logic              rsp_last
);

   plan_type               plan_ff;
   logic [SEG_NUM-1:0]     mask_ff, mask_in;
   logic [CNT_W-1:0]       rep_ff, rep_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]      rsp_code_ff;
   logic                   rsp_last_ff;

   logic [SEG_IDX_W-1:0]   seg;
   logic [SEG_NUM-1:0]     seg_bit;
   logic [SEG_NUM-1:0]     load_mask;
   logic                   out_free;
   logic                   emit;
   logic                   rep_done;
   logic                   char_last;

   // lowest pending run
   always_comb begin
      seg = '0;
      for (int i = SEG_NUM - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            seg = SEG_IDX_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SEG_NUM; i++) begin
         load_mask[i] = (pop_plan.segs[i].count != '0);
      end
   end

   assign seg_bit   = SEG_NUM'(1) << seg;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = (mask_ff != '0) && out_free;
   assign rep_done  = ((rep_ff + CNT_W'(1)) == plan_ff.segs[seg].count);
   assign char_last = rep_done && ((mask_ff & ~seg_bit) == '0);
   assign pop_ready = (mask_ff == '0);

   always_comb begin
      mask_in      = mask_ff;
      rep_in       = rep_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         if (rep_done) begin
            mask_in = mask_ff & ~seg_bit;
            rep_in  = '0;
         end else begin
            rep_in = rep_ff + CNT_W'(1);
         end
      end else if (pop_ready && pop_valid) begin
         mask_in = load_mask;
         rep_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rep_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         plan_ff <= pop_plan;
      end
      if (emit) begin
         rsp_code_ff <= plan_ff.segs[seg].code;
         rsp_last_ff <= char_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_code   = rsp_code_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
